[src/bitf_pkg.sv]
// Shared types, constants and helpers for the beacon element tail filter.
// No dependencies; every other file imports this package.
package bitf_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_OUT_LIMIT     = 256;
    localparam int DEF_CAPTURE_DEPTH = 257;

    // Widths sized for the largest supported parameter values
    localparam int CNT_W       = 13;  // output byte count, up to 4096
    localparam int LEN_W       = 9;   // capture length and address, up to 257
    localparam int HOLD_N      = 6;   // bytes held before a keep/drop decision
    localparam int MAX_RES     = 6;   // results per item at most
    localparam int QUEUE_DEPTH = 4;   // power of two

    // Element codes
    localparam logic [7:0]  EID_SSID     = 8'd0;
    localparam logic [7:0]  EID_VHT_OPER = 8'd192;
    localparam logic [7:0]  EID_VENDOR   = 8'd221;
    localparam logic [23:0] OUI_VENDOR   = 24'h0050F2;
    localparam logic [7:0]  TYPE_WMM     = 8'd2;
    localparam logic [7:0]  TYPE_WPA     = 8'd1;

    // Request and result codes
    localparam logic       REQ_BYTE    = 1'b0;
    localparam logic       REQ_FINISH  = 1'b1;
    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_LONG     = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] tail_byte;
        logic       final_byte;
    } req_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [8:0] kept_length;
        logic       run_last;
    } res_t;

    // Work handed from the parser to the result sequencer
    typedef struct packed {
        logic                   drain;    // bytes come from the capture store
        logic [2:0]             cnt;      // number of byte results
        logic [HOLD_N-1:0][7:0] bytes;    // byte results when not draining
        logic [CNT_W-1:0]       base;     // output count before this item
        logic                   cap_en;   // also write the bytes to the store
        logic [LEN_W-1:0]       addr;     // store address of the first byte
        logic                   stat_en;  // status item after the bytes
        logic [1:0]             stat;
    } cmd_t;

    function automatic logic is_dropped_id(input logic [7:0] id);
        return id == EID_SSID || id == 8'd1 || id == 8'd7 || id == 8'd32 ||
               id == 8'd42 || id == 8'd45 || id == 8'd50 || id == 8'd61 ||
               id == 8'd191 || id == EID_VHT_OPER;
    endfunction

endpackage

[src/bitf_front.sv]
// Element parser: accepts items, tracks the element walk and counters,
// and pushes one command per item that causes results. Uses bitf_pkg.
module bitf_front
    import bitf_pkg::*;
#(
    parameter int OUT_LIMIT     = DEF_OUT_LIMIT,
    parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output logic push,
    output cmd_t cmd
);

    localparam int SUM_W = CNT_W + 1;

    localparam logic [2:0] PH_ID    = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_HOLD  = 3'd2;
    localparam logic [2:0] PH_PASS  = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;
    localparam logic [2:0] PH_ENDED = 3'd5;
    localparam logic [2:0] PH_DRAIN = 3'd6;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             eid_reg, eid_next;
    logic [7:0]             br_reg, br_next;
    logic [HOLD_N-1:0][7:0] hold_reg, hold_next;
    logic [2:0]             hc_reg, hc_next;
    logic [CNT_W-1:0]       oc_reg, oc_next;
    logic [1:0]             err_reg, err_next;
    logic                   wf_reg, wf_next;
    logic [LEN_W-1:0]       wl_reg, wl_next;
    logic [LEN_W-1:0]       di_reg, di_next;
    logic                   lp_reg, lp_next;
    logic                   cap_reg, cap_next;

    logic                   do_keep;
    logic                   wpa_hit;
    logic [23:0]            oui;
    logic [SUM_W-1:0]       token;
    logic [2:0]             phase_eff;
    logic [1:0]             err_eff;
    logic [LEN_W-1:0]       di_eff;
    logic [LEN_W-1:0]       rem;
    logic [2:0]             k;

    always_comb
    begin
        phase_next = phase_reg;
        eid_next   = eid_reg;
        br_next    = br_reg;
        hold_next  = hold_reg;
        hc_next    = hc_reg;
        oc_next    = oc_reg;
        err_next   = err_reg;
        wf_next    = wf_reg;
        wl_next    = wl_reg;
        di_next    = di_reg;
        lp_next    = lp_reg;
        cap_next   = cap_reg;
        push       = 1'b0;
        cmd        = '0;
        do_keep    = 1'b0;
        wpa_hit    = 1'b0;
        oui        = '0;
        token      = '0;
        phase_eff  = phase_reg;
        err_eff    = err_reg;
        di_eff     = di_reg;
        rem        = '0;
        k          = '0;

        if (accept && req.req_type == REQ_BYTE)
        begin
            // Advance the element walk by one byte
            unique case (phase_reg)
                PH_ID:
                begin
                    eid_next   = req.tail_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    br_next = req.tail_byte;
                    if (!req.final_byte)
                    begin
                        hold_next[0] = eid_reg;
                        hold_next[1] = req.tail_byte;
                        hc_next      = 3'd2;
                        if (is_dropped_id(eid_reg))
                            phase_next = (req.tail_byte != 8'd0) ? PH_SKIP : PH_ID;
                        else if (eid_reg == EID_VENDOR && req.tail_byte >= 8'd4)
                            phase_next = PH_HOLD;
                        else
                            do_keep = 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    hold_next[hc_reg] = req.tail_byte;
                    hc_next           = hc_reg + 3'd1;
                    br_next           = br_reg - 8'd1;
                    if (hc_reg == 3'(HOLD_N - 1))
                    begin
                        oui = {hold_next[2], hold_next[3], hold_next[4]};
                        if (oui == OUI_VENDOR && hold_next[5] == TYPE_WMM)
                        begin
                            phase_next = (br_next != 8'd0) ? PH_SKIP : PH_ID;
                        end
                        else
                        begin
                            do_keep = 1'b1;
                            wpa_hit = oui == OUI_VENDOR && hold_next[5] == TYPE_WPA &&
                                      !wf_reg;
                        end
                    end
                end
                PH_PASS:
                begin
                    push          = 1'b1;
                    cmd.cnt       = 3'd1;
                    cmd.bytes[0]  = req.tail_byte;
                    cmd.base      = oc_reg;
                    oc_next       = oc_reg + CNT_W'(1);
                    if (cap_reg && wl_reg < LEN_W'(CAPTURE_DEPTH))
                    begin
                        cmd.cap_en = 1'b1;
                        cmd.addr   = wl_reg;
                        wl_next    = wl_reg + LEN_W'(1);
                    end
                    br_next = br_reg - 8'd1;
                    if (br_next == 8'd0)
                    begin
                        phase_next = PH_ID;
                        cap_next   = 1'b0;
                    end
                end
                PH_SKIP:
                begin
                    br_next = br_reg - 8'd1;
                    if (br_next == 8'd0)
                    begin
                        if (lp_reg)
                        begin
                            err_next   = ST_LONG;
                            phase_next = PH_ENDED;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                end
                default: ;
            endcase

            // Release the held bytes, or drop the element at the output limit
            if (do_keep)
            begin
                token = SUM_W'(hold_next[1]) + SUM_W'(2);
                if (SUM_W'(oc_reg) + token > SUM_W'(OUT_LIMIT))
                begin
                    if (br_next == 8'd0)
                    begin
                        err_next   = ST_LONG;
                        phase_next = PH_ENDED;
                    end
                    else
                    begin
                        lp_next    = 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                else
                begin
                    push       = 1'b1;
                    cmd.cnt    = hc_next;
                    cmd.bytes  = hold_next;
                    cmd.base   = oc_reg;
                    oc_next    = oc_reg + CNT_W'(hc_next);
                    phase_next = (br_next != 8'd0) ? PH_PASS : PH_ID;
                    if (wpa_hit)
                    begin
                        wf_next    = 1'b1;
                        wl_next    = LEN_W'(HOLD_N);
                        cap_next   = br_next != 8'd0;
                        cmd.cap_en = 1'b1;
                        cmd.addr   = '0;
                    end
                end
            end

            // End the stream on its last byte
            if (req.final_byte && phase_reg < PH_ENDED && phase_next < PH_ENDED)
            begin
                if ((phase_next == PH_HOLD || phase_next == PH_PASS ||
                     phase_next == PH_SKIP) && br_next != 8'd0)
                    err_next = ST_TRUNC;
                phase_next = PH_ENDED;
            end
        end
        else if (accept)
        begin
            // Finish tick: close the stream, then drain capture and status
            if (phase_reg < PH_ENDED)
            begin
                if ((phase_reg == PH_HOLD || phase_reg == PH_PASS ||
                     phase_reg == PH_SKIP) && br_reg != 8'd0)
                    err_eff = ST_TRUNC;
                phase_eff = PH_ENDED;
            end
            cap_next = 1'b0;
            if (phase_eff == PH_ENDED)
            begin
                if (err_eff == ST_OK && wf_reg &&
                    SUM_W'(oc_reg) + SUM_W'(wl_reg) > SUM_W'(OUT_LIMIT))
                    err_eff = ST_LONG;
                di_eff = '0;
            end
            if (err_eff == ST_OK && wf_reg)
                rem = wl_reg - di_eff;
            k = (rem >= LEN_W'(MAX_RES)) ? 3'(MAX_RES) : rem[2:0];

            push      = 1'b1;
            cmd.drain = 1'b1;
            cmd.cnt   = k;
            cmd.addr  = di_eff;
            cmd.base  = oc_reg;
            if (k != 3'(MAX_RES))
            begin
                cmd.stat_en = 1'b1;
                if (err_eff != ST_OK)
                    cmd.stat = err_eff;
                else
                    cmd.stat = (oc_reg + CNT_W'(k) == '0) ? ST_EMPTY : ST_OK;
                phase_next = PH_ID;
                eid_next   = '0;
                br_next    = '0;
                hc_next    = '0;
                oc_next    = '0;
                err_next   = ST_OK;
                wf_next    = 1'b0;
                wl_next    = '0;
                di_next    = '0;
                lp_next    = 1'b0;
            end
            else
            begin
                phase_next = PH_DRAIN;
                di_next    = di_eff + LEN_W'(k);
                oc_next    = oc_reg + CNT_W'(k);
                err_next   = err_eff;
            end
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            eid_reg   <= '0;
            br_reg    <= '0;
            hc_reg    <= '0;
            oc_reg    <= '0;
            err_reg   <= ST_OK;
            wf_reg    <= 1'b0;
            wl_reg    <= '0;
            di_reg    <= '0;
            lp_reg    <= 1'b0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            eid_reg   <= eid_next;
            br_reg    <= br_next;
            hc_reg    <= hc_next;
            oc_reg    <= oc_next;
            err_reg   <= err_next;
            wf_reg    <= wf_next;
            wl_reg    <= wl_next;
            di_reg    <= di_next;
            lp_reg    <= lp_next;
            cap_reg   <= cap_next;
        end
    end

    // Hold element head bytes
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

[src/bitf_queue.sv]
// Short command queue between the parser and the result sequencer.
// Uses bitf_pkg for the command type and depth.
module bitf_queue
    import bitf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    input  logic pop,
    output cmd_t head,
    output logic not_empty,
    output logic full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [PTR_W:0]    cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign not_empty = cnt_reg != '0;
    assign full      = cnt_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign head      = q_mem[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and fill count
    always_comb
    begin
        wr_next  = do_push ? wr_reg + PTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_reg] <= cmd_in;
    end

endmodule

[src/bitf_back.sv]
// Result sequencer: expands each command into result items, one per cycle
// while the receiver takes them; owns the capture store and the output register. Uses bitf_pkg.
module bitf_back
    import bitf_pkg::*;
#(
    parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t head,
    input  logic head_valid,
    output logic pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int AW = $clog2(CAPTURE_DEPTH);

    logic [7:0]       store [CAPTURE_DEPTH];
    logic [7:0]       store_q;
    logic [2:0]       idx_reg, idx_next;
    logic             ov_reg, ov_next;
    logic             kind_q;
    logic [7:0]       byte_q;
    logic [1:0]       stat_q;
    logic [8:0]       kept_q;
    logic             last_q;
    logic             from_store_q;

    logic             adv;
    logic             last;
    logic             is_byte;
    logic [2:0]       total;
    logic [LEN_W-1:0] addr_sum;
    logic [AW-1:0]    store_a;
    logic [7:0]       byte_sel;
    logic [CNT_W-1:0] kept_sum;

    // Pick the next result of the head command
    always_comb
    begin
        total    = head.cnt + 3'(head.stat_en);
        last     = (idx_reg + 3'd1) == total;
        is_byte  = idx_reg < head.cnt;
        adv      = head_valid && (!ov_reg || res_ready);
        pop      = adv && last;
        addr_sum = head.addr + LEN_W'(idx_reg);
        store_a  = AW'(addr_sum);
        byte_sel = head.bytes[idx_reg];
        kept_sum = is_byte ? head.base + CNT_W'(idx_reg) + CNT_W'(1)
                           : head.base + CNT_W'(head.cnt);
        idx_next = adv ? (last ? 3'd0 : idx_reg + 3'd1) : idx_reg;
        ov_next  = adv ? 1'b1 : (res_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_q       <= is_byte ? KIND_BYTE : KIND_STATUS;
            byte_q       <= is_byte ? byte_sel : 8'd0;
            stat_q       <= is_byte ? ST_OK : head.stat;
            kept_q       <= kept_sum[8:0];
            last_q       <= last;
            from_store_q <= is_byte && head.drain;
        end
    end

    // Capture store: write captured bytes, read drained ones
    always_ff @(posedge clk)
    begin
        if (adv && is_byte && head.cap_en)
            store[store_a] <= byte_sel;
        if (adv && is_byte && head.drain)
            store_q <= store[store_a];
    end

    assign res_valid       = ov_reg;
    assign res.out_kind    = kind_q;
    assign res.out_byte    = from_store_q ? store_q : byte_q;
    assign res.status      = stat_q;
    assign res.kept_length = kept_q;
    assign res.run_last    = last_q;

endmodule

[src/beacon_ie_tail_filter.sv]
// Top level of the beacon element tail filter: parser, command queue and
// result sequencer. Depends on bitf_pkg, bitf_front, bitf_queue, bitf_back.
//
// Usage: req carries one item per handshake: a stream byte (req_type 0)
// or a finish tick (req_type 1). res carries result items: kept bytes,
// appended capture bytes and one final status item; run_last marks the
// last result caused by an item. Both channels are valid/ready.
// Throughput: one item per cycle while each item causes at most one
// result and the receiver is ready; the sequencer emits one result per
// cycle while the receiver takes them, so an item that releases the six
// held bytes or drains six capture bytes holds the result side for six results.
// A four-entry command queue lets the parser keep taking items meanwhile.
// An accepted item's command goes through the queue, then the output register.
// Drained capture bytes are read from a 257-byte store with a registered
// read port, one per cycle while the receiver is ready.
// Reset clears the parse state, the queue and the output valid flag; the
// store and the output data are not cleared. When the receiver stalls, the
// result is held, the queue fills, and req_ready drops once it is full.
module beacon_ie_tail_filter
    import bitf_pkg::*;
#(
    parameter int OUT_LIMIT     = DEF_OUT_LIMIT,
    parameter int CAPTURE_DEPTH = DEF_CAPTURE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic accept;
    logic push;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic q_full;
    logic pop;

    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    bitf_front #(
        .OUT_LIMIT     (OUT_LIMIT),
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .push   (push),
        .cmd    (cmd)
    );

    bitf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    bitf_back #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

[src/bitf_checker.sv]
// Port-level checks for the beacon element tail filter, bound to the top.
// Depends on bitf_pkg.
module bitf_checker
    import bitf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic res_valid,
    input logic res_ready,
    input res_t res
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // A status item ends its item's results
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_kind == KIND_STATUS |-> res.run_last)
        else $error("status item not last");

    // A status item carries no byte
    a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_kind == KIND_STATUS |-> res.out_byte == 8'd0)
        else $error("status item with byte");

    // A byte item carries no status
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.out_kind == KIND_BYTE |-> res.status == ST_OK)
        else $error("byte item with status");

endmodule

bind beacon_ie_tail_filter bitf_checker u_bitf_checker (.*);
